### design/dplt_pkg.sv
// Package for the demand-paging LRU translator.
// Holds the field widths, the register map and the structs passed along the frame cell chain.
// No dependencies.
`default_nettype none

package dplt_pkg;

  // Field widths of the item formats
  localparam int unsigned LA_W      = 20;
  localparam int unsigned PA_W      = 18;
  localparam int unsigned OB_W      = 4;
  localparam int unsigned OFFS_W    = 15;  // offset of a page with 15 offset bits
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned PA_CALC_W = 22;  // frame shifted by up to 15 plus offset, before masking

  // Frame index width for the largest supported frame count (64)
  localparam int unsigned FIDX_W = 6;

  // Stream data widths, padded to whole bytes
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 40;

  // Configuration port
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam logic [OB_W-1:0] OFFSET_BITS_RST = 4'd7;
  localparam logic        REG_IDX_OFFSET_BITS = 1'b0;  // paddr[2] selects the register

  // Scan token, walked from cell to cell once per item
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [FIDX_W-1:0]  hit_idx;
    logic               free;
    logic [FIDX_W-1:0]  free_idx;
    logic               best_set;
    logic [FIDX_W-1:0]  best_idx;
    logic [STAMP_W-1:0] best_stamp;
  } scan_tok_t;

  // Update broadcast to the cells when a scan finishes
  typedef struct packed {
    logic              en;     // refresh the stamp of the selected frame
    logic              claim;  // also take the frame for the current page
    logic [FIDX_W-1:0] frame;
  } commit_t;

endpackage

`default_nettype wire

### design/dplt_cell.sv
// One physical frame cell: used flag, owning page and last-access stamp.
// Folds its state into the scan token and registers it for the next cell.
// Depends on dplt_pkg.
`default_nettype none

module dplt_cell #(
  parameter int unsigned INDEX  = 0,
  parameter int unsigned PAGE_W = 5
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [PAGE_W-1:0]             page_i,
  input  wire [dplt_pkg::STAMP_W-1:0]  stamp_i,
  input  dplt_pkg::commit_t            cmt_i,
  input  dplt_pkg::scan_tok_t          tok_i,
  output dplt_pkg::scan_tok_t          tok_o
);

  localparam logic [dplt_pkg::FIDX_W-1:0] MY_IDX = dplt_pkg::FIDX_W'(INDEX);
  localparam logic                        USED_RST = (INDEX == 0);

  logic                         used_q;
  logic [PAGE_W-1:0]            owner_q;
  logic [dplt_pkg::STAMP_W-1:0] stamp_q;
  logic                         sel;
  dplt_pkg::scan_tok_t          tok_d, tok_q;

  // frame 0 is reserved: it only forwards the token
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && (INDEX != 0)) begin
      if (used_q && (owner_q == page_i)) begin
        tok_d.hit     = 1'b1;
        tok_d.hit_idx = MY_IDX;
      end
      if (!used_q && !tok_i.free) begin
        tok_d.free     = 1'b1;
        tok_d.free_idx = MY_IDX;
      end
      // strict compare keeps the lowest index on a tie
      if (!tok_i.best_set || (stamp_q < tok_i.best_stamp)) begin
        tok_d.best_set   = 1'b1;
        tok_d.best_idx   = MY_IDX;
        tok_d.best_stamp = stamp_q;
      end
    end
  end

  assign sel = cmt_i.en && (cmt_i.frame == MY_IDX);

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= USED_RST;
      stamp_q <= '0;
    end else if (sel) begin
      stamp_q <= stamp_i;
      if (cmt_i.claim) begin
        used_q <= 1'b1;
      end
    end
  end

  // owning page, written when the frame is claimed
  always_ff @(posedge clk_i) begin
    if (sel && cmt_i.claim) begin
      owner_q <= page_i;
    end
  end

  // token hand-off to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

### design/demand_paging_lru_translator.sv
// Demand-paging translator with LRU frame replacement. Each item is one logical address;
// the page number is the address shifted right by offset_bits. Pages map onto a chain of
// FRAME_COUNT frame cells (frame 0 reserved) that double as the reverse map: a scan token
// walks the chain one cell per cycle collecting hit, lowest free frame and least recent
// frame. A new item is accepted only once the previous one has left the sequencer: an
// in-range item first goes through the whole cell chain, an out-of-range item skips it,
// and both wait while the output register holds a result not yet taken. A finished result
// waits in the output register while the next item is accepted. offset_bits sits at byte
// address 0 of the APB port; write it only while the block is idle.
// Depends on dplt_pkg and dplt_cell.
`default_nettype none

module demand_paging_lru_translator #(
  parameter int unsigned PAGE_ENTRIES = 32,
  parameter int unsigned FRAME_COUNT  = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // slave stream: tdata = logical_address[19:0], zero pad
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [dplt_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // master stream: tdata = physical_address[17:0], page_fault, replaced,
  // out_of_range, replacement_count[15:0], zero pad
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [dplt_pkg::M_DATA_W-1:0]    m_axis_tdata,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [dplt_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire  [dplt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dplt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned PW = $clog2(PAGE_ENTRIES);
  localparam int unsigned FW = $clog2(FRAME_COUNT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [dplt_pkg::OB_W-1:0]    ob_q;
  logic [PW-1:0]                page_q;
  logic [dplt_pkg::OFFS_W-1:0]  offs_q;
  logic                         launch_q;
  logic [dplt_pkg::STAMP_W-1:0] aclk_q, aclk_next;
  logic [dplt_pkg::CNT_W-1:0]   evict_q, evict_d;
  logic [dplt_pkg::M_DATA_W-1:0] res_q;
  logic                         m_valid_q;
  logic [dplt_pkg::M_DATA_W-1:0] m_data_q;

  logic                         in_acc;
  logic                         cfg_wr;
  logic [dplt_pkg::LA_W-1:0]    la;
  logic [dplt_pkg::LA_W-1:0]    page_full;
  logic [dplt_pkg::LA_W-1:0]    offs_full;
  logic                         oor;

  dplt_pkg::scan_tok_t          tok [FRAME_COUNT+1];
  dplt_pkg::scan_tok_t          tok_end;
  dplt_pkg::commit_t            cmt;
  logic [FW-1:0]                frame;
  logic                         repl;
  logic [dplt_pkg::PA_CALC_W-1:0] pa_calc;
  logic                         out_free;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == dplt_pkg::REG_IDX_OFFSET_BITS)
                ? dplt_pkg::APB_DATA_W'(ob_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_q <= dplt_pkg::OFFSET_BITS_RST;
    end else if (cfg_wr && (paddr[2] == dplt_pkg::REG_IDX_OFFSET_BITS)) begin
      ob_q <= pwdata[dplt_pkg::OB_W-1:0];
    end
  end

  // address split at the input
  assign la            = s_axis_tdata[dplt_pkg::LA_W-1:0];
  assign page_full     = la >> ob_q;
  assign offs_full     = la & ~({dplt_pkg::LA_W{1'b1}} << ob_q);
  assign oor           = page_full >= dplt_pkg::LA_W'(PAGE_ENTRIES);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // scan token launched the cycle after acceptance
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = launch_q;
  end

  for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
    dplt_cell #(
      .INDEX  (i),
      .PAGE_W (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .page_i  (page_q),
      .stamp_i (aclk_next),
      .cmt_i   (cmt),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
  end

  assign tok_end = tok[FRAME_COUNT];

  // frame choice: hit, else lowest free, else least recent
  always_comb begin
    if (tok_end.hit) begin
      frame = tok_end.hit_idx[FW-1:0];
    end else if (tok_end.free) begin
      frame = tok_end.free_idx[FW-1:0];
    end else begin
      frame = tok_end.best_idx[FW-1:0];
    end
    repl      = !tok_end.hit && !tok_end.free;
    aclk_next = aclk_q + 1'b1;
    cmt.en    = tok_end.valid;
    cmt.claim = !tok_end.hit;
    cmt.frame = dplt_pkg::FIDX_W'(frame);
    evict_d   = evict_q;
    if (repl && (evict_q != {dplt_pkg::CNT_W{1'b1}})) begin
      evict_d = evict_q + 1'b1;
    end
    pa_calc = (dplt_pkg::PA_CALC_W'(frame) << ob_q) + dplt_pkg::PA_CALC_W'(offs_q);
  end

  assign out_free = !m_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = oor ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_end.valid) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      launch_q <= 1'b0;
      aclk_q   <= '0;
      evict_q  <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= in_acc && !oor;
      if (tok_end.valid) begin
        aclk_q  <= aclk_next;
        evict_q <= evict_d;
      end
    end
  end

  // item payload and pending result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      page_q <= page_full[PW-1:0];
      offs_q <= offs_full[dplt_pkg::OFFS_W-1:0];
      if (oor) begin
        res_q <= {3'b000, evict_q, 1'b1, 1'b0, 1'b0, {dplt_pkg::PA_W{1'b0}}};
      end
    end else if (tok_end.valid) begin
      res_q <= {3'b000, evict_d, 1'b0, repl, !tok_end.hit, pa_calc[dplt_pkg::PA_W-1:0]};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      m_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire
